FILE: design/tat_pkg.sv
// ----------------------------------------------------------------------------
// Typed argument tokenizer package
// Shared types, codes and character constants of the tokenizer.
// ----------------------------------------------------------------------------
package tat_pkg;

	localparam int MAX_ARGS_DEF = 16;
	localparam int MAX_LEN_DEF = 256;
	localparam logic [4:0] MAX_ARGS_RESET = 5'd16;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	localparam logic [1:0] TY_STRING = 2'd0;
	localparam logic [1:0] TY_INT = 2'd1;
	localparam logic [1:0] TY_FLOAT = 2'd2;
	localparam logic [1:0] TY_BOOL = 2'd3;

	localparam logic [2:0] ST_ARG = 3'd0;
	localparam logic [2:0] ST_TOO_MANY = 3'd1;
	localparam logic [2:0] ST_BAD = 3'd2;
	localparam logic [2:0] ST_END = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STRING,
		MODE_NUMBER,
		MODE_FLOAT,
		MODE_BOOLEAN,
		MODE_TAIL
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  tok_start;
		logic [7:0]  tok_len;
		logic        after_bs;
		logic        stopped;
		logic [1:0]  tail_type;
	} tok_t;

	typedef struct packed {
		logic [3:0]  arg_index;
		logic [1:0]  arg_type;
		logic [7:0]  start_offset;
		logic [7:0]  content_length;
		logic [2:0]  status;
		logic        list_done;
	} res_t;

	localparam tok_t TOK_RESET = '{
		mode: MODE_IDLE,
		tok_start: 8'd0,
		tok_len: 8'd0,
		after_bs: 1'b0,
		stopped: 1'b0,
		tail_type: TY_STRING
	};

endpackage

FILE: design/tat_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Next state and optional result for one character, from the current state.
// ----------------------------------------------------------------------------
module tat_step import tat_pkg::*; #(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF,
	localparam int AW = $clog2(MAX_ARGS + 1),
	localparam int PW = $clog2(MAX_LEN + 1)
) (
	input  logic [7:0]    sym,
	input  logic [4:0]    max_args,
	input  tok_t          tok,
	input  logic [AW-1:0] count,
	input  logic [PW-1:0] pos,
	output tok_t          tok_nxt,
	output logic [AW-1:0] count_nxt,
	output logic [PW-1:0] pos_nxt,
	output logic          res_valid,
	output res_t          res
);

	localparam int LW = (AW > 5) ? AW : 5;
	localparam logic [LW-1:0] ARGS_CAP = LW'(MAX_ARGS);
	localparam logic [PW-1:0] LEN_CAP = PW'(MAX_LEN);

	logic            blank;
	logic            digit;
	logic            close;
	logic [LW-1:0]   limit;
	logic            do_fail;
	logic [2:0]      fail_code;
	logic            do_fin;
	logic [1:0]      fin_type;
	logic            step;
	logic            restart;
	logic [1:0]      cur_type;
	logic [7:0]      len_grown;

	assign blank = (sym == CH_SPACE) || (sym == CH_TAB);
	assign digit = sym inside {[CH_ZERO:CH_NINE]};
	assign close = (sym == CH_NUL) || (sym == CH_COMMA);
	assign limit = (LW'(max_args) > ARGS_CAP) ? ARGS_CAP : LW'(max_args);
	assign len_grown = (tok.tok_len == 8'hFF) ? tok.tok_len : tok.tok_len + 8'd1;

	always_comb begin
		tok_nxt = tok;
		count_nxt = count;
		pos_nxt = pos;
		res_valid = 1'b0;
		res = '0;
		do_fail = 1'b0;
		fail_code = ST_BAD;
		do_fin = 1'b0;
		fin_type = TY_STRING;
		step = 1'b0;
		restart = 1'b0;
		cur_type = TY_BOOL;

		if (tok.stopped) begin
			restart = (sym == CH_NUL);
		end else if (pos >= LEN_CAP) begin
			do_fail = 1'b1;
			fail_code = ST_TOO_LONG;
		end else begin
			case (tok.mode)
				MODE_IDLE: begin
					if (sym == CH_NUL) begin
						res_valid = 1'b1;
						res.arg_index = 4'(count);
						res.start_offset = 8'(pos);
						res.status = ST_END;
						res.list_done = 1'b1;
						restart = 1'b1;
					end else if (blank) begin
						step = 1'b1;
					end else if (sym == CH_QUOTE) begin
						tok_nxt.mode = MODE_STRING;
						tok_nxt.tok_start = 8'(pos) + 8'd1;
						tok_nxt.tok_len = 8'd0;
						tok_nxt.after_bs = 1'b0;
						step = 1'b1;
					end else if (digit || sym == CH_T || sym == CH_F) begin
						tok_nxt.mode = digit ? MODE_NUMBER : MODE_BOOLEAN;
						tok_nxt.tok_start = 8'(pos);
						tok_nxt.tok_len = 8'd1;
						step = 1'b1;
					end else begin
						do_fail = 1'b1;
					end
				end
				MODE_STRING: begin
					if (sym == CH_NUL) begin
						do_fail = 1'b1;
					end else if (tok.after_bs) begin
						tok_nxt.tok_len = len_grown;
						tok_nxt.after_bs = 1'b0;
						step = 1'b1;
					end else if (sym == CH_BACKSLASH) begin
						tok_nxt.tok_len = len_grown;
						tok_nxt.after_bs = 1'b1;
						step = 1'b1;
					end else if (sym == CH_QUOTE) begin
						tok_nxt.mode = MODE_TAIL;
						tok_nxt.tail_type = TY_STRING;
						step = 1'b1;
					end else begin
						tok_nxt.tok_len = len_grown;
						step = 1'b1;
					end
				end
				MODE_NUMBER, MODE_FLOAT, MODE_BOOLEAN: begin
					if (tok.mode == MODE_NUMBER) begin
						cur_type = TY_INT;
					end else if (tok.mode == MODE_FLOAT) begin
						cur_type = TY_FLOAT;
					end
					if (close) begin
						do_fin = 1'b1;
						fin_type = cur_type;
					end else if (blank) begin
						tok_nxt.mode = MODE_TAIL;
						tok_nxt.tail_type = cur_type;
						step = 1'b1;
					end else if (tok.mode == MODE_BOOLEAN || digit) begin
						tok_nxt.tok_len = len_grown;
						step = 1'b1;
					end else if (tok.mode == MODE_NUMBER && sym == CH_DOT) begin
						tok_nxt.mode = MODE_FLOAT;
						tok_nxt.tok_len = len_grown;
						step = 1'b1;
					end else begin
						do_fail = 1'b1;
					end
				end
				MODE_TAIL: begin
					if (close) begin
						do_fin = 1'b1;
						fin_type = tok.tail_type;
					end else if (!blank) begin
						do_fail = 1'b1;
					end else begin
						step = 1'b1;
					end
				end
				default: begin
					do_fail = 1'b1;
				end
			endcase
		end

		if (do_fin) begin
			if (LW'(count) >= limit) begin
				do_fail = 1'b1;
				fail_code = ST_TOO_MANY;
			end else begin
				res_valid = 1'b1;
				res.arg_index = 4'(count);
				res.arg_type = fin_type;
				res.start_offset = tok.tok_start;
				res.content_length = tok.tok_len;
				res.status = ST_ARG;
				res.list_done = (sym == CH_NUL);
				if (sym == CH_NUL) begin
					restart = 1'b1;
				end else begin
					count_nxt = count + AW'(1);
					tok_nxt.mode = MODE_IDLE;
					tok_nxt.tok_len = 8'd0;
					step = 1'b1;
				end
			end
		end

		if (do_fail) begin
			res_valid = 1'b1;
			res = '0;
			res.arg_index = 4'(count);
			res.start_offset = 8'(pos);
			res.status = fail_code;
			res.list_done = 1'b1;
			if (sym == CH_NUL) begin
				restart = 1'b1;
			end else begin
				tok_nxt.stopped = 1'b1;
			end
		end

		if (step) begin
			pos_nxt = pos + PW'(1);
		end

		if (restart) begin
			tok_nxt = TOK_RESET;
			count_nxt = '0;
			pos_nxt = '0;
		end
	end

endmodule

FILE: design/typed_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// Typed argument tokenizer
// An accepted character is registered in the input stage; its result is registered at the output when
// the input stage advances. Throughput: one character per cycle while the output is not stalled.
// Reset clears the parser to the start of a list and max_args to 16.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module typed_argument_tokenizer import tat_pkg::*; #(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] max_args,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] arg_index,
	output logic [1:0] arg_type,
	output logic [7:0] start_offset,
	output logic [7:0] content_length,
	output logic [2:0] status,
	output logic       list_done
);

	localparam int AW = $clog2(MAX_ARGS + 1);
	localparam int PW = $clog2(MAX_LEN + 1);

	logic [4:0]    max_args_q;
	logic [7:0]    sym_s1;
	logic          valid_s1;
	tok_t          tok_q;
	tok_t          tok_nxt;
	logic [AW-1:0] count_q;
	logic [AW-1:0] count_nxt;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_nxt;
	logic          res_valid;
	res_t          res;
	res_t          res_q;
	logic          out_valid_q;
	logic          adv;

	assign cfg_ready = 1'b1;
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	tat_step #(
		.MAX_ARGS(MAX_ARGS),
		.MAX_LEN(MAX_LEN)
	) u_step (
		.sym(sym_s1),
		.max_args(max_args_q),
		.tok(tok_q),
		.count(count_q),
		.pos(pos_q),
		.tok_nxt(tok_nxt),
		.count_nxt(count_nxt),
		.pos_nxt(pos_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= MAX_ARGS_RESET;
			valid_s1 <= 1'b0;
			tok_q <= TOK_RESET;
			count_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_args_q <= max_args;
			end
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				tok_q <= tok_nxt;
				count_q <= count_nxt;
				pos_q <= pos_nxt;
			end
			if (adv && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sym_s1 <= symbol;
		end
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign arg_index = res_q.arg_index;
	assign arg_type = res_q.arg_type;
	assign start_offset = res_q.start_offset;
	assign content_length = res_q.content_length;
	assign status = res_q.status;
	assign list_done = res_q.list_done;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with the input stage empty");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pos_q) && $stable(count_q))
		else $error("parser state moved without a character");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(MAX_ARGS))
		else $error("argument count beyond its limit");

	a_list_closed: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_valid && res.list_done |=>
			(pos_q == '0 && count_q == '0) || tok_q.stopped)
		else $error("list not closed after a closing result");

endmodule
